// ===== src/ngga_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package ngga_pkg;

	localparam int INT_W = 20;
	localparam int FRAC_W = 20;
	localparam int MIN_COMMAS = 14;
	localparam int HEAD_LEN = 6;
	localparam logic [20:0] RECIP_100 = 21'd1342178;
	localparam int SHIFT_100 = 27;
	localparam logic [30:0] RECIP_60 = 31'd1145324613;
	localparam int SHIFT_60 = 36;
	localparam logic [7:0] CHAR_COMMA = 8'h2c;
	localparam logic [7:0] CHAR_DOT = 8'h2e;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_BAD_PREFIX = 3'd1,
		ST_FEW_COMMAS = 3'd2,
		ST_TIME_SHORT = 3'd3,
		ST_TIME_RANGE = 3'd4,
		ST_TOO_LONG = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		PH_INT,
		PH_FRAC,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic last_char;
	} in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] hours;
		logic [6:0] mins;
		logic [6:0] secs;
		logic [31:0] lat_e7;
		logic [7:0] lat_hemi;
		logic [31:0] lon_e7;
		logic [7:0] lon_hemi;
	} out_t;

	typedef struct packed {
		logic [INT_W-1:0] ival;
		logic [FRAC_W-1:0] fval;
		logic [2:0] fcnt;
	} coord_t;

	typedef struct packed {
		status_t status;
		logic [6:0] hours;
		logic [6:0] mins;
		logic [6:0] secs;
		coord_t [1:0] coord;
		logic [1:0][7:0] hemi;
	} record_t;

	function automatic logic [19:0] pow10(input logic [2:0] n);
		logic [19:0] r;
		case (n)
			3'd0: r = 20'd1;
			3'd1: r = 20'd10;
			3'd2: r = 20'd100;
			3'd3: r = 20'd1000;
			3'd4: r = 20'd10000;
			3'd5: r = 20'd100000;
			3'd6: r = 20'd1000000;
			default: r = 20'd1;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] head_char(input logic [2:0] n);
		logic [7:0] r;
		case (n)
			3'd0: r = 8'h24;
			3'd1: r = 8'h47;
			3'd2: r = 8'h50;
			3'd3: r = 8'h47;
			3'd4: r = 8'h47;
			3'd5: r = 8'h41;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic [6:0] pair_value(input logic [7:0] a, input logic [7:0] b);
		logic [6:0] da;
		logic [6:0] db;
		logic [6:0] r;
		da = 7'(a[3:0]);
		db = 7'(b[3:0]);
		r = 7'd0;
		if (is_digit(a)) begin
			r = is_digit(b) ? 7'(da * 7'd10 + db) : da;
		end else if (a == 8'h20 || (a >= 8'h09 && a <= 8'h0d) || a == 8'h2b) begin
			r = is_digit(b) ? db : 7'd0;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/ngga_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ngga_front #(
	parameter int MAX_LINE = 255,
	parameter int FRAC_DIGITS = 4,
	parameter int INT_DIGITS = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic char_valid,
	input wire ngga_pkg::in_t char_data,
	input wire logic full,
	output logic push,
	output ngga_pkg::record_t rec
);

	localparam int CW = $clog2(MAX_LINE + 1);
	localparam int IW = $clog2(int'(ngga_pkg::pow10(3'(INT_DIGITS))));
	localparam int FW = $clog2(int'(ngga_pkg::pow10(3'(FRAC_DIGITS))));
	localparam logic [IW+3:0] INT_MAX = (IW+4)'(ngga_pkg::pow10(3'(INT_DIGITS)) - 20'd1);

	logic [CW-1:0] cnt_q, cnt_n;
	logic prefix_q, prefix_n;
	logic [3:0] comma_q, comma_n;
	logic [2:0] tidx_q, tidx_n;
	logic in_tok_q, in_tok_n;
	logic [2:0] tlen_q, tlen_n;
	logic [7:0] tdig_q [6];
	logic [7:0] tdig_n [6];
	logic [IW-1:0] cint_q [2];
	logic [IW-1:0] cint_n [2];
	logic [FW-1:0] cfrac_q [2];
	logic [FW-1:0] cfrac_n [2];
	ngga_pkg::phase_t cph_q [2];
	ngga_pkg::phase_t cph_n [2];
	logic [2:0] fcnt_q [2];
	logic [2:0] fcnt_n [2];
	logic [7:0] hemi_q [2];
	logic [7:0] hemi_n [2];
	logic [7:0] hnew_q [2];
	logic [7:0] hnew_n [2];
	logic hseen_q [2];
	logic hseen_n [2];
	logic long_q, long_n;
	logic acc;

	always_comb begin
		logic [7:0] c;
		logic [2:0] tok;
		logic [IW+3:0] iv;
		logic [FW+3:0] fv;
		logic feed;
		c = char_data.char_byte;
		acc = char_valid && !full;
		push = acc && char_data.last_char;
		cnt_n = cnt_q;
		prefix_n = prefix_q;
		comma_n = comma_q;
		tidx_n = tidx_q;
		in_tok_n = in_tok_q;
		tlen_n = tlen_q;
		long_n = long_q;
		tok = 3'd0;
		iv = '0;
		fv = '0;
		feed = 1'b0;
		for (int k = 0; k < 6; k++) begin
			tdig_n[k] = tdig_q[k];
		end
		for (int k = 0; k < 2; k++) begin
			cint_n[k] = cint_q[k];
			cfrac_n[k] = cfrac_q[k];
			cph_n[k] = cph_q[k];
			fcnt_n[k] = fcnt_q[k];
			hemi_n[k] = hemi_q[k];
			hnew_n[k] = hnew_q[k];
			hseen_n[k] = hseen_q[k];
		end
		if (!long_q) begin
			if (cnt_q >= CW'(MAX_LINE)) begin
				long_n = 1'b1;
			end else begin
				cnt_n = cnt_q + 1'b1;
			end
		end
		if (cnt_q < CW'(ngga_pkg::HEAD_LEN) && c != ngga_pkg::head_char(cnt_q[2:0])) begin
			prefix_n = 1'b0;
		end
		if (c == ngga_pkg::CHAR_COMMA) begin
			if (comma_q != 4'd15) begin
				comma_n = comma_q + 4'd1;
			end
			in_tok_n = 1'b0;
		end else begin
			if (!in_tok_q) begin
				in_tok_n = 1'b1;
				if (tidx_q != 3'd7) begin
					tidx_n = tidx_q + 3'd1;
				end
				tok = tidx_n - 3'd1;
				if (tok == 3'd3) begin
					hnew_n[0] = c;
					hseen_n[0] = 1'b1;
				end
				if (tok == 3'd5) begin
					hnew_n[1] = c;
					hseen_n[1] = 1'b1;
				end
			end
			tok = tidx_n - 3'd1;
			if (tok == 3'd1 && tlen_q < 3'd6) begin
				tdig_n[tlen_q] = c;
				tlen_n = tlen_q + 3'd1;
			end
			for (int k = 0; k < 2; k++) begin
				feed = (k == 0) ? (tok == 3'd2) : (tok == 3'd4);
				if (feed) begin
					case (cph_q[k])
						ngga_pkg::PH_INT: begin
							if (ngga_pkg::is_digit(c)) begin
								iv = (IW+4)'(cint_q[k]) * (IW+4)'(10) + (IW+4)'(c[3:0]);
								cint_n[k] = (iv > INT_MAX) ? INT_MAX[IW-1:0] : iv[IW-1:0];
							end else if (c == ngga_pkg::CHAR_DOT) begin
								cph_n[k] = ngga_pkg::PH_FRAC;
							end else begin
								cph_n[k] = ngga_pkg::PH_DONE;
							end
						end
						ngga_pkg::PH_FRAC: begin
							if (ngga_pkg::is_digit(c)) begin
								if (fcnt_q[k] < 3'(FRAC_DIGITS)) begin
									fv = (FW+4)'(cfrac_q[k]) * (FW+4)'(10) + (FW+4)'(c[3:0]);
									cfrac_n[k] = fv[FW-1:0];
									fcnt_n[k] = fcnt_q[k] + 3'd1;
								end
							end else begin
								cph_n[k] = ngga_pkg::PH_DONE;
							end
						end
						default: begin
						end
					endcase
				end
			end
		end

		rec = '0;
		if (cnt_n < CW'(ngga_pkg::HEAD_LEN) || !prefix_n) begin
			rec.status = ngga_pkg::ST_BAD_PREFIX;
		end else if (comma_n < 4'(ngga_pkg::MIN_COMMAS)) begin
			rec.status = ngga_pkg::ST_FEW_COMMAS;
		end else if (long_n) begin
			rec.status = ngga_pkg::ST_TOO_LONG;
		end else begin
			for (int k = 0; k < 2; k++) begin
				if (hseen_n[k] && char_data.last_char) begin
					hemi_n[k] = hnew_n[k];
				end
				rec.coord[k].ival = ngga_pkg::INT_W'(cint_n[k]);
				rec.coord[k].fval = ngga_pkg::FRAC_W'(cfrac_n[k]);
				rec.coord[k].fcnt = fcnt_n[k];
			end
			if (tlen_n < 3'd6) begin
				rec.status = ngga_pkg::ST_TIME_SHORT;
			end else begin
				rec.hours = ngga_pkg::pair_value(tdig_n[0], tdig_n[1]);
				rec.mins = ngga_pkg::pair_value(tdig_n[2], tdig_n[3]);
				rec.secs = ngga_pkg::pair_value(tdig_n[4], tdig_n[5]);
				rec.status = (rec.hours > 7'd23 || rec.mins > 7'd59 || rec.secs > 7'd59) ?
					ngga_pkg::ST_TIME_RANGE : ngga_pkg::ST_OK;
			end
		end
		rec.hemi[0] = hemi_n[0];
		rec.hemi[1] = hemi_n[1];

		if (char_data.last_char) begin
			cnt_n = '0;
			prefix_n = 1'b1;
			comma_n = '0;
			tidx_n = '0;
			in_tok_n = 1'b0;
			tlen_n = '0;
			long_n = 1'b0;
			for (int k = 0; k < 6; k++) begin
				tdig_n[k] = '0;
			end
			for (int k = 0; k < 2; k++) begin
				cint_n[k] = '0;
				cfrac_n[k] = '0;
				cph_n[k] = ngga_pkg::PH_INT;
				fcnt_n[k] = '0;
				hnew_n[k] = '0;
				hseen_n[k] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			prefix_q <= 1'b1;
			comma_q <= '0;
			tidx_q <= '0;
			in_tok_q <= 1'b0;
			tlen_q <= '0;
			long_q <= 1'b0;
			for (int k = 0; k < 6; k++) begin
				tdig_q[k] <= '0;
			end
			for (int k = 0; k < 2; k++) begin
				cint_q[k] <= '0;
				cfrac_q[k] <= '0;
				cph_q[k] <= ngga_pkg::PH_INT;
				fcnt_q[k] <= '0;
				hemi_q[k] <= '0;
				hnew_q[k] <= '0;
				hseen_q[k] <= 1'b0;
			end
		end else if (acc) begin
			cnt_q <= cnt_n;
			prefix_q <= prefix_n;
			comma_q <= comma_n;
			tidx_q <= tidx_n;
			in_tok_q <= in_tok_n;
			tlen_q <= tlen_n;
			long_q <= long_n;
			for (int k = 0; k < 6; k++) begin
				tdig_q[k] <= tdig_n[k];
			end
			for (int k = 0; k < 2; k++) begin
				cint_q[k] <= cint_n[k];
				cfrac_q[k] <= cfrac_n[k];
				cph_q[k] <= cph_n[k];
				fcnt_q[k] <= fcnt_n[k];
				hemi_q[k] <= hemi_n[k];
				hnew_q[k] <= hnew_n[k];
				hseen_q[k] <= hseen_n[k];
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/ngga_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ngga_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire ngga_pkg::record_t wdata,
	output logic full,
	output logic rvalid,
	output ngga_pkg::record_t rdata,
	input wire logic pop
);

	ngga_pkg::record_t mem_q [2];
	logic wr_q;
	logic rd_q;
	logic [1:0] count_q;

	assign full = (count_q == 2'd2);
	assign rvalid = (count_q != 2'd0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("queue count out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != 2'd0)
		else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== src/ngga_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ngga_back #(
	parameter int FRAC_DIGITS = 4
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic rec_valid,
	input wire ngga_pkg::record_t rec,
	output logic pop,
	output logic res_valid,
	input wire logic res_stall,
	output ngga_pkg::out_t res_data
);

	localparam logic [26:0] SCALE = 27'(ngga_pkg::pow10(3'(FRAC_DIGITS)));
	localparam logic [29:0] UP = 30'(ngga_pkg::pow10(3'(7 - FRAC_DIGITS)));

	logic en;
	logic v_s1, v_s2, v_s3, v_s4;
	ngga_pkg::record_t m_s1, m_s2, m_s3;
	logic [13:0] q_s1 [2];
	logic [13:0] q_s2 [2];
	logic [13:0] q_s3 [2];
	logic [19:0] i_s1 [2];
	logic [19:0] fp_s1 [2];
	logic [29:0] x_s2 [2];
	logic [23:0] fr_s3 [2];
	logic [13:0] q_c [2];
	logic [19:0] fp_c [2];
	logic [29:0] x_c [2];
	logic [23:0] fr_c [2];
	logic [31:0] e7_c [2];
	ngga_pkg::out_t res_q;

	assign en = !v_s4 || !res_stall;
	assign pop = en && rec_valid;
	assign res_valid = v_s4;
	assign res_data = res_q;

	always_comb begin
		logic [40:0] p100;
		logic [39:0] pad;
		logic [19:0] r20;
		logic [26:0] ms;
		logic [60:0] p60;
		logic [39:0] t;
		for (int k = 0; k < 2; k++) begin
			p100 = 41'(rec.coord[k].ival) * 41'(ngga_pkg::RECIP_100);
			q_c[k] = p100[ngga_pkg::SHIFT_100 +: 14];
			pad = 40'(rec.coord[k].fval) *
				40'(ngga_pkg::pow10(3'(FRAC_DIGITS) - rec.coord[k].fcnt));
			fp_c[k] = pad[19:0];
			r20 = i_s1[k] - 20'(q_s1[k]) * 20'd100;
			ms = 27'(r20[6:0]) * SCALE + 27'(fp_s1[k]);
			x_c[k] = 30'(ms) * UP;
			p60 = 61'(x_s2[k]) * 61'(ngga_pkg::RECIP_60);
			fr_c[k] = p60[ngga_pkg::SHIFT_60 +: 24];
			t = 40'(q_s3[k]) * 40'd10000000 + 40'(fr_s3[k]);
			e7_c[k] = (t > 40'hFFFFFFFF) ? 32'hFFFFFFFF : t[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1 <= rec;
			m_s2 <= m_s1;
			m_s3 <= m_s2;
			for (int k = 0; k < 2; k++) begin
				q_s1[k] <= q_c[k];
				i_s1[k] <= rec.coord[k].ival;
				fp_s1[k] <= fp_c[k];
				q_s2[k] <= q_s1[k];
				x_s2[k] <= x_c[k];
				q_s3[k] <= q_s2[k];
				fr_s3[k] <= fr_c[k];
			end
			res_q.status <= m_s3.status;
			res_q.hours <= m_s3.hours;
			res_q.mins <= m_s3.mins;
			res_q.secs <= m_s3.secs;
			res_q.lat_e7 <= e7_c[0];
			res_q.lat_hemi <= m_s3.hemi[0];
			res_q.lon_e7 <= e7_c[1];
			res_q.lon_hemi <= m_s3.hemi[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= rec_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && (res_q.status == ngga_pkg::ST_BAD_PREFIX ||
			res_q.status == ngga_pkg::ST_FEW_COMMAS ||
			res_q.status == ngga_pkg::ST_TOO_LONG) |->
			res_q.lat_e7 == 32'd0 && res_q.lon_e7 == 32'd0)
		else $error("rejected sentence carries a coordinate");

	a_range_flag: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && res_q.status == ngga_pkg::ST_OK |->
			res_q.hours <= 7'd23 && res_q.mins <= 7'd59 && res_q.secs <= 7'd59)
		else $error("accepted time out of range");

endmodule
`default_nettype wire

// ===== src/nmea_gga_sentence_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Handshake               Payload
// char      in         char_valid, char_stall  char_data (char_byte, last_char)
// res       out        res_valid, res_stall    res_data (status .. lon_hemi)
//
// One character is taken per cycle while char_stall is low and updates the scanner state.
// A popped record moves through registers s1, s2, s3 and the result register to res_data.
// The conversion is fully pipelined; one result per cycle while res_stall is low.
// Reset clears all sentence state and the held hemisphere bytes.
// char_stall rises only while the two-entry record queue is full.
module nmea_gga_sentence_parser #(
	parameter int MAX_LINE = 255,
	parameter int FRAC_DIGITS = 4,
	parameter int INT_DIGITS = 5
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic char_valid,
	output logic char_stall,
	input wire ngga_pkg::in_t char_data,
	output logic res_valid,
	input wire logic res_stall,
	output ngga_pkg::out_t res_data
);

	logic full;
	logic push;
	logic rvalid;
	logic pop;
	ngga_pkg::record_t wrec;
	ngga_pkg::record_t rrec;

	assign char_stall = full;

	ngga_front #(
		.MAX_LINE(MAX_LINE),
		.FRAC_DIGITS(FRAC_DIGITS),
		.INT_DIGITS(INT_DIGITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_data(char_data),
		.full(full),
		.push(push),
		.rec(wrec)
	);

	ngga_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wdata(wrec),
		.full(full),
		.rvalid(rvalid),
		.rdata(rrec),
		.pop(pop)
	);

	ngga_back #(
		.FRAC_DIGITS(FRAC_DIGITS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.rec_valid(rvalid),
		.rec(rrec),
		.pop(pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

endmodule
`default_nettype wire

// ===== dv/nmea_gga_sentence_parser_test.sv =====
`timescale 1ns / 1ps
module nmea_gga_sentence_parser_test;

	localparam int MAX_CHARS = 255;
	localparam int FRAC_N = 4;
	localparam int INT_N = 5;
	localparam int IDLE_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic char_valid = 1'b0;
	logic char_stall;
	ngga_pkg::in_t char_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	ngga_pkg::out_t res_data;

	nmea_gga_sentence_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_stall(char_stall),
		.char_data(char_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data)
	);

	always #5 clk = ~clk;

	ngga_pkg::in_t pending_chars[$];
	ngga_pkg::out_t expected_results[$];
	int errors = 0;
	int idle_cycles = 0;
	bit stimulus_done = 0;
	int burst_left = 0;
	int gap_left = 0;
	int hold_left = 0;
	int long_holds = 0;

	// Parser shadow state.
	int unsigned p_count;
	bit p_prefix;
	int unsigned p_commas;
	int unsigned p_token;
	bit p_in_token;
	int unsigned p_tlen;
	logic [7:0] p_tdig[6];
	longint unsigned p_int[2];
	longint unsigned p_frac[2];
	ngga_pkg::phase_t p_phase[2];
	int unsigned p_fcnt[2];
	logic [7:0] p_hemi[2];
	bit p_long;
	logic [7:0] p_hnew[2];
	bit p_hseen[2];

	function automatic bit digit_char(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic int unsigned time_pair(logic [7:0] a, logic [7:0] b);
		if (digit_char(a))
			return digit_char(b) ? (a - "0") * 10 + (b - "0") : a - "0";
		if (a == " " || (a >= 9 && a <= 13) || a == "+")
			return digit_char(b) ? b - "0" : 0;
		return 0;
	endfunction

	function automatic longint unsigned pow_ten(int n);
		longint unsigned r;
		r = 1;
		repeat (n) r = r * 10;
		return r;
	endfunction

	task automatic clear_sentence();
		p_count = 0;
		p_prefix = 1;
		p_commas = 0;
		p_token = 0;
		p_in_token = 0;
		p_tlen = 0;
		p_long = 0;
		for (int k = 0; k < 6; k++) p_tdig[k] = 0;
		for (int k = 0; k < 2; k++) begin
			p_int[k] = 0;
			p_frac[k] = 0;
			p_phase[k] = ngga_pkg::PH_INT;
			p_fcnt[k] = 0;
			p_hnew[k] = 0;
			p_hseen[k] = 0;
		end
	endtask

	task automatic feed_coord(int k, logic [7:0] c);
		longint unsigned v;
		if (p_phase[k] == ngga_pkg::PH_INT) begin
			if (digit_char(c)) begin
				v = p_int[k] * 10 + (c - "0");
				p_int[k] = v > pow_ten(INT_N) - 1 ? pow_ten(INT_N) - 1 : v;
			end else if (c == ".") begin
				p_phase[k] = ngga_pkg::PH_FRAC;
			end else begin
				p_phase[k] = ngga_pkg::PH_DONE;
			end
		end else if (p_phase[k] == ngga_pkg::PH_FRAC) begin
			if (digit_char(c)) begin
				if (p_fcnt[k] < FRAC_N) begin
					p_frac[k] = p_frac[k] * 10 + (c - "0");
					p_fcnt[k]++;
				end
			end else begin
				p_phase[k] = ngga_pkg::PH_DONE;
			end
		end
	endtask

	function automatic logic [31:0] degrees_e7(int k);
		longint unsigned scale, f, ms, r;
		scale = pow_ten(FRAC_N);
		f = p_frac[k] * pow_ten(FRAC_N - p_fcnt[k]);
		ms = (p_int[k] % 100) * scale + f;
		r = (p_int[k] / 100) * 64'd10000000 + (ms * 64'd10000000) / (60 * scale);
		return r > 64'hFFFFFFFF ? 32'hFFFFFFFF : r[31:0];
	endfunction

	task automatic parse_char(ngga_pkg::in_t it);
		logic [7:0] c;
		int unsigned pos, tok;
		ngga_pkg::out_t r;
		c = it.char_byte;
		pos = p_count;
		if (!p_long) begin
			if (pos >= MAX_CHARS) p_long = 1;
			else p_count++;
		end
		if (pos < 6 && c != (("$GPGGA" >> (8 * (5 - pos))) & 8'hFF)) p_prefix = 0;
		if (c == ",") begin
			if (p_commas < 15) p_commas++;
			p_in_token = 0;
		end else begin
			if (!p_in_token) begin
				p_in_token = 1;
				if (p_token < 7) p_token++;
				tok = p_token - 1;
				if (tok == 3) begin
					p_hnew[0] = c;
					p_hseen[0] = 1;
				end
				if (tok == 5) begin
					p_hnew[1] = c;
					p_hseen[1] = 1;
				end
			end
			tok = p_token - 1;
			if (tok == 1) begin
				if (p_tlen < 6) begin
					p_tdig[p_tlen] = c;
					p_tlen++;
				end
			end else if (tok == 2) begin
				feed_coord(0, c);
			end else if (tok == 4) begin
				feed_coord(1, c);
			end
		end
		if (!it.last_char) return;
		r = '0;
		if (p_count < 6 || !p_prefix) begin
			r.status = ngga_pkg::ST_BAD_PREFIX;
		end else if (p_commas < 14) begin
			r.status = ngga_pkg::ST_FEW_COMMAS;
		end else if (p_long) begin
			r.status = ngga_pkg::ST_TOO_LONG;
		end else begin
			for (int k = 0; k < 2; k++) if (p_hseen[k]) p_hemi[k] = p_hnew[k];
			r.lat_e7 = degrees_e7(0);
			r.lon_e7 = degrees_e7(1);
			if (p_tlen < 6) begin
				r.status = ngga_pkg::ST_TIME_SHORT;
			end else begin
				r.hours = time_pair(p_tdig[0], p_tdig[1]);
				r.mins = time_pair(p_tdig[2], p_tdig[3]);
				r.secs = time_pair(p_tdig[4], p_tdig[5]);
				r.status = (r.hours > 23 || r.mins > 59 || r.secs > 59) ?
					ngga_pkg::ST_TIME_RANGE : ngga_pkg::ST_OK;
			end
		end
		r.lat_hemi = p_hemi[0];
		r.lon_hemi = p_hemi[1];
		expected_results.push_back(r);
		clear_sentence();
	endtask

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic queue_text(string s);
		ngga_pkg::in_t it;
		for (int i = 0; i < s.len(); i++) begin
			it.char_byte = s[i];
			it.last_char = (i == s.len() - 1);
			pending_chars.push_back(it);
		end
	endtask

	function automatic string rand_digits(int n);
		string s;
		s = "";
		repeat (n) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
		return s;
	endfunction

	function automatic string rand_field();
		string s;
		s = "";
		repeat ($urandom_range(0, 4)) s = {s, string'(8'($urandom_range(0, 255)))};
		return s;
	endfunction

	function automatic string rand_coord();
		string s;
		case ($urandom_range(0, 5))
			0: return "";
			1: return rand_field();
			2: return {rand_digits($urandom_range(7, 9)), ".", rand_digits($urandom_range(0, 8))};
			default: begin
				s = {rand_digits($urandom_range(1, 5)), "."};
				return {s, rand_digits($urandom_range(0, 6))};
			end
		endcase
	endfunction

	function automatic string rand_time();
		string lead;
		lead = " +-\t";
		case ($urandom_range(0, 6))
			0: return "";
			1: return rand_field();
			2: return rand_digits($urandom_range(1, 5));
			3: return {string'(8'(lead[$urandom_range(0, 3)])), rand_digits(5)};
			4: return rand_digits($urandom_range(6, 9));
			default: return $sformatf("%02d%02d%02d.%0d", $urandom_range(0, 25),
				$urandom_range(0, 61), $urandom_range(0, 61), $urandom_range(0, 99));
		endcase
	endfunction

	function automatic string rand_sentence();
		string s, hemi;
		int commas;
		s = ($urandom_range(0, 9) == 0) ? "$GPGGB" : "$GPGGA";
		hemi = "NSEW";
		s = {s, ",", rand_time(), ",", rand_coord(), ","};
		if ($urandom_range(0, 4) != 0) s = {s, string'(8'(hemi[$urandom_range(0, 3)]))};
		else if ($urandom_range(0, 1)) s = {s, string'(8'($urandom_range(0, 255)))};
		s = {s, ",", rand_coord(), ","};
		if ($urandom_range(0, 4) != 0) s = {s, string'(8'(hemi[$urandom_range(0, 3)]))};
		commas = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(9, 12);
		repeat (commas) s = {s, ",", rand_field()};
		if ($urandom_range(0, 30) == 0) repeat (260) s = {s, "9"};
		return s;
	endfunction

	initial begin
		string s;
		clear_sentence();
		p_hemi[0] = 0;
		p_hemi[1] = 0;
		queue_text("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47");
		queue_text("$GPGGA,235959,9959.99999,S,99999.9999,W,,,,,,,,,,");
		queue_text("$GPGGA,240000,0000.0,,0.0,,,,,,,,,,,,");
		queue_text("$GPGGA,12,,,,,,,,,,,,,,");
		queue_text("$GPGG");
		queue_text("$GPGGA,1,2");
		queue_text("X");
		s = "$GPGGA,000000,1.2,N,3.4,E";
		repeat (12) s = {s, ","};
		repeat (240) s = {s, "0"};
		queue_text(s);
		for (int i = 0; i < 256; i++) begin
			ngga_pkg::in_t it;
			it.char_byte = 8'(i);
			it.last_char = (i == 255);
			pending_chars.push_back(it);
		end
		while (pending_chars.size() < 1750) queue_text(rand_sentence());
		stimulus_done = 1;
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (char_valid && !char_stall) begin
				parse_char(char_data);
				void'(pending_chars.pop_front());
			end
			if (char_valid && char_stall) begin
				char_valid <= 1'b1;
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				char_valid <= 1'b0;
			end else if (pending_chars.size() > 0) begin
				char_valid <= 1'b1;
				char_data <= pending_chars[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
				end else if (burst_left == 1) begin
					burst_left <= 0;
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				char_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result", 1, 0);
				end else begin
					ngga_pkg::out_t w;
					w = expected_results.pop_front();
					if (res_data.status !== w.status)
						report_mismatch("status", res_data.status, w.status);
					if (res_data.hours !== w.hours)
						report_mismatch("hours", res_data.hours, w.hours);
					if (res_data.mins !== w.mins)
						report_mismatch("mins", res_data.mins, w.mins);
					if (res_data.secs !== w.secs)
						report_mismatch("secs", res_data.secs, w.secs);
					if (res_data.lat_e7 !== w.lat_e7)
						report_mismatch("lat_e7", res_data.lat_e7, w.lat_e7);
					if (res_data.lat_hemi !== w.lat_hemi)
						report_mismatch("lat_hemi", res_data.lat_hemi, w.lat_hemi);
					if (res_data.lon_e7 !== w.lon_e7)
						report_mismatch("lon_e7", res_data.lon_e7, w.lon_e7);
					if (res_data.lon_hemi !== w.lon_hemi)
						report_mismatch("lon_hemi", res_data.lon_hemi, w.lon_hemi);
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_stall <= 1'b1;
			end else if (long_holds < 2 && expected_results.size() > 0 &&
				$urandom_range(0, 40) == 0) begin
				long_holds <= long_holds + 1;
				hold_left <= 400;
				res_stall <= 1'b1;
			end else if ($urandom_range(0, 255) < 64) begin
				hold_left <= $urandom_range(0, 4);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	// The long receiver hold counts as progress so the watchdog only sees real hangs.
	always @(posedge clk) begin
		if ((char_valid && !char_stall) || (res_valid && !res_stall) || hold_left > 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (arst_n);
		wait (stimulus_done && pending_chars.size() == 0 && !char_valid);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

endmodule
